// ===== src/cec_pkg.sv =====
// Shared constants and the month start table for the calendar/epoch converter.
// No dependencies; imported by calendar_epoch_converter.
package cec_pkg;

    // Opcodes
    localparam logic OP_TO_EPOCH = 1'b0;
    localparam logic OP_TO_DATE  = 1'b1;

    // Day counts from 1970-01-01
    localparam logic [16:0] DAYS_TO_2000 = 17'd10957;
    localparam logic [16:0] DAYS_TO_2100 = 17'd47482;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [10:0] DAYS_PER_QUAD = 11'd1461;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;

    // Reciprocals for exact floor division by constants
    // days = ((ts >> 7) * RCP_DAY) >> 35, exact for 25-bit operands (86400 = 128 * 675)
    localparam logic [25:0] RCP_DAY  = 26'd50903317;
    // quad = (d * RCP_QUAD) >> 27, exact for 16-bit operands
    localparam logic [16:0] RCP_QUAD = 17'd91868;
    // hour = ((s >> 4) * RCP_HOUR) >> 21, exact for 13-bit operands (3600 = 16 * 225)
    localparam logic [13:0] RCP_HOUR = 14'd9321;
    // minute = ((s >> 2) * RCP_MIN) >> 14, exact for 10-bit operands (60 = 4 * 15)
    localparam logic [10:0] RCP_MIN  = 11'd1093;

    // Day of year on which a month starts; months past December start at year end
    function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
        logic [8:0] base;
        logic       add_leap;
        base     = 9'd0;
        add_leap = (month >= 4'd3) && leap;
        case (month)
            4'd0, 4'd1: base = 9'd0;
            4'd2:       base = 9'd31;
            4'd3:       base = 9'd59;
            4'd4:       base = 9'd90;
            4'd5:       base = 9'd120;
            4'd6:       base = 9'd151;
            4'd7:       base = 9'd181;
            4'd8:       base = 9'd212;
            4'd9:       base = 9'd243;
            4'd10:      base = 9'd273;
            4'd11:      base = 9'd304;
            4'd12:      base = 9'd334;
            default:    base = 9'd365;
        endcase
        return base + {8'd0, add_leap};
    endfunction

endpackage

// ===== src/calendar_epoch_converter.sv =====
// Calendar date/time <-> Unix epoch seconds converter, six-stage pipeline.
// Depends on cec_pkg for constants and the month start table.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | i_valid / o_stall   | i_opcode, i_year_offset, i_month_in, i_day_in,
//          |                     | i_hour_in, i_minute_in, i_second_in, i_epoch_in
//  out     | o_valid / i_stall   | o_epoch_out, o_year_out, o_month_out, o_day_out,
//          |                     | o_hour_out, o_minute_out, o_second_out, o_result_valid
//
// One word per cycle is sustained while the output is not stalled; the chain of constant
// reciprocal multipliers (day, four-year cycle, hour, minute) sets the depth.
// Reset (synchronous, active low) clears the stage valid bits only.
// The whole pipeline, bubbles included, holds while a valid output word is stalled;
// with the output register empty the pipeline advances under stall, so only
// a bubble in the output register is squeezed out.
module calendar_epoch_converter import cec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [6:0]  i_year_offset,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    input  logic [4:0]  i_hour_in,
    input  logic [5:0]  i_minute_in,
    input  logic [5:0]  i_second_in,
    input  logic [31:0] i_epoch_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_epoch_out,
    output logic [6:0]  o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic        o_result_valid
);

    logic en;
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // Valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            o_valid <= r_v5;
        end
    end

    // ---------------- Stage 1: day count (both directions), time of day
    logic [7:0]  n1_yo_p3;
    logic [5:0]  n1_leaps;
    logic        n1_leap;
    logic [16:0] n1_days0;
    logic [16:0] n1_tod;
    logic [50:0] n1_dprod;

    logic        r1_op;
    logic        r1_yo_ok;
    logic [16:0] r1_days0;
    logic [16:0] r1_tod;
    logic [15:0] r1_days;
    logic [16:0] r1_ts_lo;

    always_comb begin
        n1_yo_p3 = {1'b0, i_year_offset} + 8'd3;
        // 2100 inside the wrapped offset range is not a leap year
        n1_leaps = n1_yo_p3[7:2] - ((i_year_offset > 7'd100) ? 6'd1 : 6'd0);
        n1_leap  = (i_year_offset[1:0] == 2'b00) && (i_year_offset != 7'd100);
        n1_days0 = DAYS_TO_2000 + {10'd0, i_year_offset} * {8'd0, DAYS_PER_YEAR}
                 + {11'd0, n1_leaps} + {8'd0, month_start(i_month_in, n1_leap)}
                 + {12'd0, i_day_in} - 17'd1;
        n1_tod   = {12'd0, i_hour_in} * {5'd0, SECS_PER_HOUR}
                 + {11'd0, i_minute_in} * {5'd0, SECS_PER_MIN}
                 + {11'd0, i_second_in};
        n1_dprod = {26'd0, i_epoch_in[31:7]} * {25'd0, RCP_DAY};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op    <= i_opcode;
            r1_yo_ok <= (i_year_offset <= 7'd99);
            r1_days0 <= n1_days0;
            r1_tod   <= n1_tod;
            r1_days  <= n1_dprod[50:35];
            r1_ts_lo <= i_epoch_in[16:0];
        end
    end

    // ---------------- Stage 2: epoch seconds; seconds of day and range check
    logic [33:0] n2_dsec0;
    logic [32:0] n2_dsec;

    logic        r2_op;
    logic        r2_yo_ok;
    logic [31:0] r2_epoch;
    logic [16:0] r2_secs;
    logic [15:0] r2_d2;
    logic        r2_inrange;

    always_comb begin
        n2_dsec0 = {17'd0, r1_days0} * {17'd0, SECS_PER_DAY};
        n2_dsec  = {17'd0, r1_days} * {16'd0, SECS_PER_DAY};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op      <= r1_op;
            r2_yo_ok   <= r1_yo_ok;
            r2_epoch   <= n2_dsec0[31:0] + {15'd0, r1_tod};
            r2_secs    <= r1_ts_lo - n2_dsec[16:0];
            r2_d2      <= r1_days - DAYS_TO_2000[15:0];
            r2_inrange <= ({1'b0, r1_days} >= DAYS_TO_2000)
                       && ({1'b0, r1_days} < DAYS_TO_2100);
        end
    end

    // ---------------- Stage 3: four-year cycle and hour
    logic [32:0] n3_qprod;
    logic [26:0] n3_hprod;

    logic        r3_op;
    logic        r3_yo_ok;
    logic [31:0] r3_epoch;
    logic [16:0] r3_secs;
    logic [15:0] r3_d2;
    logic        r3_inrange;
    logic [4:0]  r3_quad;
    logic [4:0]  r3_hour;

    always_comb begin
        n3_qprod = {17'd0, r2_d2} * {16'd0, RCP_QUAD};
        n3_hprod = {14'd0, r2_secs[16:4]} * {13'd0, RCP_HOUR};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_op      <= r2_op;
            r3_yo_ok   <= r2_yo_ok;
            r3_epoch   <= r2_epoch;
            r3_secs    <= r2_secs;
            r3_d2      <= r2_d2;
            r3_inrange <= r2_inrange;
            r3_quad    <= n3_qprod[31:27];
            r3_hour    <= n3_hprod[25:21];
        end
    end

    // ---------------- Stage 4: day within cycle, seconds within hour
    logic [15:0] n4_qdays;
    logic [16:0] n4_hsecs;

    logic        r4_op;
    logic        r4_yo_ok;
    logic [31:0] r4_epoch;
    logic        r4_inrange;
    logic [4:0]  r4_quad;
    logic [4:0]  r4_hour;
    logic [10:0] r4_qday;
    logic [11:0] r4_remh;

    always_comb begin
        n4_qdays = {11'd0, r3_quad} * {5'd0, DAYS_PER_QUAD};
        n4_hsecs = {12'd0, r3_hour} * {5'd0, SECS_PER_HOUR};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_op      <= r3_op;
            r4_yo_ok   <= r3_yo_ok;
            r4_epoch   <= r3_epoch;
            r4_inrange <= r3_inrange;
            r4_quad    <= r3_quad;
            r4_hour    <= r3_hour;
            r4_qday    <= r3_d2[10:0] - n4_qdays[10:0];
            r4_remh    <= r3_secs[11:0] - n4_hsecs[11:0];
        end
    end

    // ---------------- Stage 5: year and day of year; minute
    logic [1:0]  n5_yic;
    logic [10:0] n5_doy;
    logic [20:0] n5_mprod;

    logic        r5_op;
    logic        r5_yo_ok;
    logic [31:0] r5_epoch;
    logic        r5_inrange;
    logic [4:0]  r5_hour;
    logic [11:0] r5_remh;
    logic [6:0]  r5_year;
    logic        r5_leap;
    logic [8:0]  r5_doy;
    logic [5:0]  r5_min;

    // First year of each cycle is the leap year
    always_comb begin
        if (r4_qday < 11'd366) begin
            n5_yic = 2'd0;
            n5_doy = r4_qday;
        end else if (r4_qday < 11'd731) begin
            n5_yic = 2'd1;
            n5_doy = r4_qday - 11'd366;
        end else if (r4_qday < 11'd1096) begin
            n5_yic = 2'd2;
            n5_doy = r4_qday - 11'd731;
        end else begin
            n5_yic = 2'd3;
            n5_doy = r4_qday - 11'd1096;
        end
        n5_mprod = {11'd0, r4_remh[11:2]} * {10'd0, RCP_MIN};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_op      <= r4_op;
            r5_yo_ok   <= r4_yo_ok;
            r5_epoch   <= r4_epoch;
            r5_inrange <= r4_inrange;
            r5_hour    <= r4_hour;
            r5_remh    <= r4_remh;
            r5_year    <= {r4_quad, n5_yic};
            r5_leap    <= (n5_yic == 2'd0);
            r5_doy     <= n5_doy[8:0];
            r5_min     <= n5_mprod[19:14];
        end
    end

    // ---------------- Stage 6: month and day search, second; output word
    logic [3:0]  n6_month;
    logic [8:0]  n6_mday;
    logic [11:0] n6_msecs;

    always_comb begin
        n6_month = 4'd1;
        for (int m = 2; m <= 12; m++) begin
            if (r5_doy >= month_start(4'(m), r5_leap)) begin
                n6_month = 4'(m);
            end
        end
        n6_mday  = r5_doy - month_start(n6_month, r5_leap) + 9'd1;
        n6_msecs = {6'd0, r5_min} * SECS_PER_MIN;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r5_op == OP_TO_EPOCH) begin
                o_epoch_out    <= r5_epoch;
                o_year_out     <= 7'd0;
                o_month_out    <= 4'd0;
                o_day_out      <= 5'd0;
                o_hour_out     <= 5'd0;
                o_minute_out   <= 6'd0;
                o_second_out   <= 6'd0;
                o_result_valid <= r5_yo_ok;
            end else if (r5_inrange) begin
                o_epoch_out    <= 32'd0;
                o_year_out     <= r5_year;
                o_month_out    <= n6_month;
                o_day_out      <= n6_mday[4:0];
                o_hour_out     <= r5_hour;
                o_minute_out   <= r5_min;
                o_second_out   <= r5_remh[5:0] - n6_msecs[5:0];
                o_result_valid <= 1'b1;
            end else begin
                // Drop date fields outside 2000..2099
                o_epoch_out    <= 32'd0;
                o_year_out     <= 7'd0;
                o_month_out    <= 4'd0;
                o_day_out      <= 5'd0;
                o_hour_out     <= 5'd0;
                o_minute_out   <= 6'd0;
                o_second_out   <= 6'd0;
                o_result_valid <= 1'b0;
            end
        end
    end

endmodule
